>>> hw/rtl/led_timed_pattern_queue_defines.svh
`ifndef LED_TIMED_PATTERN_QUEUE_DEFINES_SVH
`define LED_TIMED_PATTERN_QUEUE_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted
`define LTPQ_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error("led_timed_pattern_queue: check failed");

// Next-cycle implication, held off while reset is asserted
`define LTPQ_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error("led_timed_pattern_queue: check failed");

`endif

>>> hw/rtl/ltpq_pkg.sv
`default_nettype none

package ltpq_pkg;

	localparam int QUEUE_DEPTH_DEF = 128;

	localparam int IN_W      = 40;
	localparam int OUT_W     = 24;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 16;
	localparam int REG_W     = 15;

	localparam logic [REG_W-1:0] HOLD_RESET  = 15'd100;
	localparam logic [REG_W-1:0] FLASH_RESET = 15'd70;

	typedef enum logic [2:0] {
		CMD_TICK   = 3'd0,
		CMD_KEEP   = 3'd1,
		CMD_ON_FOR = 3'd2,
		CMD_FLASH  = 3'd3,
		CMD_FLASHI = 3'd4
	} cmd_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HOLD  = 2'd0,
		REG_FLASH = 2'd1
	} reg_idx_e;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TICK,
		ST_PUSH,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic        level;
		logic [15:0] stime;
	} step_t;

endpackage

`default_nettype wire

>>> hw/rtl/led_timed_pattern_queue.sv
// LED timed pattern queue.
// Input stream s_*: one command transaction per item, s_tdata = command [2:0],
// duration [18:3], count [34:19]. Output stream m_*: one result per item,
// m_tdata = led_level [0], queue_count [8:1], steps_added [16:9].
// Config channel cfg_*: index 0 hold time, 1 flash time, low 15 data bits kept;
// cfg_ready is always high. Write only while no item is in flight.
// Steps (level, 16-bit time) sit in a single-port-write memory of QUEUE_DEPTH
// entries with registered read. One item is worked on at a time:
//   tick: from accept through head step update (write-back of the reduced time,
//         or pop of an expired step), result load and idle;
//   push: one memory write per cycle until no steps remain or the queue is
//         full, then an end step and result load; a flash writes up to QUEUE_DEPTH steps;
//   tick on an empty queue or unused command: straight to result load.
// The result sits in an output register; the block accepts the next item
// while it waits, and only stalls before loading the following result.
// Reset clears the queue, turns the LED off and restores the default times;
// the step memory is not cleared, its entries are written before use.
`default_nettype none

module led_timed_pattern_queue #(
	parameter int QUEUE_DEPTH = ltpq_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            s_tvalid,
	output logic                           s_tready,
	input  wire  [ltpq_pkg::IN_W-1:0]      s_tdata,   // command, duration, count, pad
	output logic                           m_tvalid,
	input  wire                            m_tready,
	output logic [ltpq_pkg::OUT_W-1:0]     m_tdata,   // led_level, queue_count, steps_added, pad
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire  [ltpq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire  [ltpq_pkg::CFG_W-1:0]     cfg_data
);
	import ltpq_pkg::*;

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	step_t            mem_wdata;
	logic [IDX_W-1:0] mem_raddr;
	step_t            mem_rdata;

	ltpq_ctrl #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.IDX_W      (IDX_W),
		.CNT_W      (CNT_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	ltpq_step_mem #(
		.DEPTH(QUEUE_DEPTH),
		.IDX_W(IDX_W)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule

`default_nettype wire

>>> hw/rtl/ltpq_step_mem.sv
`default_nettype none

module ltpq_step_mem #(
	parameter int DEPTH = 128,
	parameter int IDX_W = 7
) (
	input  wire                  clk,
	input  wire                  we,
	input  wire  [IDX_W-1:0]     waddr,
	input  ltpq_pkg::step_t      wdata,
	input  wire  [IDX_W-1:0]     raddr,
	output ltpq_pkg::step_t      rdata
);
	import ltpq_pkg::*;

	step_t mem [DEPTH];
	step_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> hw/rtl/ltpq_ctrl.sv
`default_nettype none

module ltpq_ctrl #(
	parameter int QUEUE_DEPTH = 128,
	parameter int IDX_W       = 7,
	parameter int CNT_W       = 8
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	input  wire  [ltpq_pkg::IN_W-1:0]          s_tdata,
	output logic                               m_tvalid,
	input  wire                                m_tready,
	output logic [ltpq_pkg::OUT_W-1:0]         m_tdata,
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire  [ltpq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [ltpq_pkg::CFG_W-1:0]         cfg_data,
	output logic                               mem_we,
	output logic [IDX_W-1:0]                   mem_waddr,
	output ltpq_pkg::step_t                    mem_wdata,
	output logic [IDX_W-1:0]                   mem_raddr,
	input  ltpq_pkg::step_t                    mem_rdata
);
	import ltpq_pkg::*;

	state_t state_q, state_d;

	logic [15:0]      dur_q;
	logic [16:0]      rem_q;
	logic [15:0]      on_time_q;
	logic [15:0]      off_time_q;
	logic             level_q;
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] added_q;
	logic             drive_q;
	logic [REG_W-1:0] hold_q;
	logic [REG_W-1:0] flash_q;
	logic             m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;

	logic [2:0]       in_cmd;
	logic [15:0]      in_dur;
	logic [15:0]      in_cnt;
	logic             accept;
	logic             full;
	logic             tick_live;
	logic             push_go;
	logic             out_load;
	logic [15:0]      hold_ext;
	logic [15:0]      flash_ext;
	logic [IDX_W-1:0] head_next;
	logic [IDX_W-1:0] tail_next;
	logic [CNT_W+7:0] count_wide;
	logic [CNT_W+7:0] added_wide;

	assign in_cmd    = s_tdata[2:0];
	assign in_dur    = s_tdata[18:3];
	assign in_cnt    = s_tdata[34:19];
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign hold_ext  = {1'b0, hold_q};
	assign flash_ext = {1'b0, flash_q};
	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_next = (head_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_next = (tail_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;

	// A step is still running while its time is positive as a signed value
	assign tick_live = (mem_rdata.stime != 16'd0) && !mem_rdata.stime[15];
	assign push_go   = (state_q == ST_PUSH) && (rem_q != 17'd0) && !full;
	assign out_load  = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	// The head entry is read every cycle; only the read issued at accept is used
	assign mem_raddr = head_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = tail_q;
		mem_wdata = '{level: level_q, stime: level_q ? on_time_q : off_time_q};
		if (state_q == ST_TICK && tick_live) begin
			mem_we    = 1'b1;
			mem_waddr = head_q;
			mem_wdata = '{level: mem_rdata.level, stime: mem_rdata.stime - dur_q};
		end else if (push_go) begin
			mem_we = 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					priority case (in_cmd)
						CMD_TICK:   state_d = (count_q == '0) ? ST_DONE : ST_TICK;
						CMD_KEEP,
						CMD_ON_FOR,
						CMD_FLASH,
						CMD_FLASHI: state_d = ST_PUSH;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_TICK: state_d = ST_DONE;
			ST_PUSH: begin
				if (rem_q == 17'd0 || full) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q  <= HOLD_RESET;
			flash_q <= FLASH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_HOLD) begin
				hold_q <= cfg_data[REG_W-1:0];
			end else if (cfg_index == REG_FLASH) begin
				flash_q <= cfg_data[REG_W-1:0];
			end
		end
	end

	// Latch the push plan at accept: remaining steps and the on and off times
	always_ff @(posedge clk) begin
		if (accept) begin
			dur_q   <= in_dur;
			level_q <= 1'b1;
			priority case (in_cmd)
				CMD_KEEP: begin
					rem_q      <= 17'd1;
					on_time_q  <= hold_ext;
					off_time_q <= hold_ext;
				end
				CMD_ON_FOR: begin
					rem_q      <= 17'd2;
					on_time_q  <= in_dur;
					off_time_q <= hold_ext;
				end
				CMD_FLASH: begin
					rem_q      <= {in_cnt, 1'b0};
					on_time_q  <= flash_ext;
					off_time_q <= flash_ext;
				end
				CMD_FLASHI: begin
					rem_q      <= {in_cnt, 1'b0};
					on_time_q  <= in_dur;
					off_time_q <= in_dur;
				end
				default: begin
					rem_q      <= 17'd0;
					on_time_q  <= in_dur;
					off_time_q <= in_dur;
				end
			endcase
		end else if (push_go) begin
			rem_q   <= rem_q - 17'd1;
			level_q <= !level_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			added_q <= '0;
			drive_q <= 1'b0;
		end else begin
			if (accept) begin
				added_q <= '0;
			end
			if (state_q == ST_TICK) begin
				if (tick_live) begin
					drive_q <= mem_rdata.level;
				end else begin
					head_q  <= head_next;
					count_q <= count_q - 1'b1;
				end
			end
			if (push_go) begin
				tail_q  <= tail_next;
				count_q <= count_q + 1'b1;
				added_q <= added_q + 1'b1;
			end
		end
	end

	assign count_wide = {8'b0, count_q};
	assign added_wide = {8'b0, added_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {7'b0, added_wide[7:0], count_wide[7:0], drive_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

>>> hw/rtl/ltpq_checker.sv
`default_nettype none

`include "led_timed_pattern_queue_defines.svh"

module ltpq_checker #(
	parameter int QUEUE_DEPTH = ltpq_pkg::QUEUE_DEPTH_DEF
) (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        s_tvalid,
	input wire                        s_tready,
	input wire                        m_tvalid,
	input wire                        m_tready,
	input wire [ltpq_pkg::OUT_W-1:0]  m_tdata
);

	// Hold a stalled result
	`LTPQ_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// One item at a time: no second transaction straight after an accepted one
	`LTPQ_ASSERT_NEXT(a_one_item, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// The reported queue count never exceeds the queue depth (checked for depths up to 255)
	`LTPQ_ASSERT_IMP(a_count_bound, clk, arst_n, m_tvalid, (QUEUE_DEPTH > 255) || (m_tdata[8:1] <= QUEUE_DEPTH))

	// Steps added by an item are all still counted in the queue
	`LTPQ_ASSERT_IMP(a_added_bound, clk, arst_n, m_tvalid, (QUEUE_DEPTH > 255) || (m_tdata[16:9] <= m_tdata[8:1]))

endmodule

bind led_timed_pattern_queue ltpq_checker #(
	.QUEUE_DEPTH(QUEUE_DEPTH)
) u_ltpq_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

`default_nettype wire
